// ----- rtl/rhle_pkg.sv -----
package rhle_pkg;

  // Default escape threshold for the timestamp delta.
  localparam int unsigned ESCAPE_LIMIT_DEF = 268435455;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_STREAM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME   = 1'b1;

  // One classified record, handed from the front to the back.
  typedef struct packed {
    logic        escape;
    logic [63:0] delta;
    logic [7:0]  sid;
    logic        multi;
    logic [31:0] cnt;
  } cmd_t;

  // Serializer phases of the back end.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_U    = 4'b0010,
    PH_S    = 4'b0100,
    PH_SID  = 4'b1000
  } phase_t;

endpackage

// ----- rtl/rhle_front.sv -----
module rhle_front #(
  parameter int unsigned ESCAPE_LIMIT = rhle_pkg::ESCAPE_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rhle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           push,
  input  logic signed [63:0]             time_ms,
  input  logic [7:0]                     stream_id,
  input  logic                           q_full,
  output logic                           q_wr,
  output rhle_pkg::cmd_t                 q_data
);
  import rhle_pkg::*;

  logic        multi_stream;
  logic [63:0] last_time;
  logic [31:0] record_total;
  logic [63:0] delta;
  logic        accept;

  // Wrapping delta and escape classification.
  assign delta  = time_ms - last_time;
  assign accept = push && !q_full;
  assign q_wr   = accept;

  always_comb begin
    q_data.escape = delta[63] || (delta >= 64'(ESCAPE_LIMIT));
    q_data.delta  = delta;
    q_data.sid    = stream_id;
    q_data.multi  = multi_stream;
    q_data.cnt    = record_total + 32'd1;
  end

  // Configuration registers and per-record state.
  always_ff @(posedge clk) begin
    if (rst) begin
      multi_stream <= 1'b0;
      last_time    <= '0;
      record_total <= '0;
    end else begin
      if (accept) begin
        last_time    <= time_ms;
        record_total <= record_total + 32'd1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MULTI_STREAM: multi_stream <= cfg_data[0];
          REG_START_TIME: begin
            last_time    <= cfg_data;
            record_total <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  a_last_time: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_we |=> last_time == $past(time_ms))
    else $error("last timestamp not taken from accepted item");

  a_count: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_we |=> record_total == $past(record_total) + 32'd1)
    else $error("record count did not advance");

endmodule

// ----- rtl/rhle_queue.sv -----
module rhle_queue #(
  parameter int unsigned DEPTH = rhle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  rhle_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd,
  output rhle_pkg::cmd_t rd_data,
  output logic           q_empty
);
  import rhle_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("write into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd && q_empty))
    else $error("read from empty queue");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    wr && !rd |=> count == $past(count) + CW'(1))
    else $error("fill count did not follow a write");

endmodule

// ----- rtl/rhle_back.sv -----
module rhle_back #(
  parameter int unsigned ESCAPE_LIMIT = rhle_pkg::ESCAPE_LIMIT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  rhle_pkg::cmd_t q_data,
  output logic           q_rd,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           last_byte,
  output logic [31:0]    records_written
);
  import rhle_pkg::*;

  // Unsigned part holds either the escape value or a small delta.
  localparam int unsigned UW = $clog2(ESCAPE_LIMIT + 1) + 1;

  phase_t        phase;
  phase_t        phase_next;
  logic          escape;
  logic          multi;
  logic [7:0]    sid;
  logic [31:0]   cnt;
  logic [UW-1:0] u;
  logic [63:0]   s;
  logic [63:0]   s_shift;
  logic          u_more;
  logic          s_done;
  logic          out_valid;
  logic          adv;
  logic          emit;
  logic          item_done;
  logic [7:0]    cur_byte;

  assign empty   = !out_valid;
  assign adv     = !out_valid || pop;
  assign u_more  = |u[UW-1:7];
  assign s_shift = {{7{s[63]}}, s[63:7]};
  assign s_done  = ((s_shift == '0) && !s[6]) || ((s_shift == '1) && s[6]);
  assign q_rd    = adv && ((phase == PH_IDLE) || item_done) && !q_empty;

  // Byte selection and phase sequencing for the item in flight.
  always_comb begin
    emit       = 1'b1;
    item_done  = 1'b0;
    cur_byte   = '0;
    phase_next = phase;
    unique case (phase)
      PH_U: begin
        cur_byte = {u_more, u[6:0]};
        if (!u_more) begin
          if (escape) begin
            phase_next = PH_S;
          end else if (multi) begin
            phase_next = PH_SID;
          end else begin
            item_done = 1'b1;
          end
        end
      end
      PH_S: begin
        cur_byte = {!s_done, s[6:0]};
        if (s_done) begin
          if (multi) begin
            phase_next = PH_SID;
          end else begin
            item_done = 1'b1;
          end
        end
      end
      PH_SID: begin
        cur_byte  = sid;
        item_done = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_byte        <= cur_byte;
      last_byte       <= item_done;
      records_written <= cnt;
    end
  end

  // Serializer state: shift on each byte, load the next item when idle or at the end of one.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (adv) begin
      if (q_rd) begin
        phase <= PH_U;
      end else if (item_done) begin
        phase <= PH_IDLE;
      end else begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_rd) begin
        escape <= q_data.escape;
        multi  <= q_data.multi;
        sid    <= q_data.sid;
        cnt    <= q_data.cnt;
        u      <= q_data.escape ? UW'(ESCAPE_LIMIT) : q_data.delta[UW-1:0];
        s      <= q_data.delta;
      end else begin
        if (phase == PH_U) begin
          u <= u >> 7;
        end
        if (phase == PH_S) begin
          s <= s_shift;
        end
      end
    end
  end

  a_read_valid: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("command taken from empty queue");

  a_sid_multi: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SID |-> multi)
    else $error("stream byte outside multi-stream mode");

  a_s_escape: assert property (@(posedge clk) disable iff (rst)
    phase == PH_S |-> escape)
    else $error("signed delta without escape");

endmodule

// ----- rtl/record_header_delta_leb128_encoder.sv -----
// An accepted item is written into the command queue, then loaded into the
// serializer, and its first header byte then goes to the output register.
// Throughput: one header byte per cycle while pop keeps the output drained;
// a header has 1 to 15 bytes, and a queued item follows with no gap.
// Reset (rst, synchronous): queue and output empty, multi-stream off, last
// timestamp and record count zero.
module record_header_delta_leb128_encoder #(
  parameter int unsigned ESCAPE_LIMIT = rhle_pkg::ESCAPE_LIMIT_DEF,
  parameter int unsigned QUEUE_DEPTH  = rhle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rhle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic signed [63:0]             time_ms,
  input  logic [7:0]                     stream_id,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     out_byte,
  output logic                           last_byte,
  output logic [31:0]                    records_written
);
  import rhle_pkg::*;

  logic q_wr;
  logic q_rd;
  logic q_full;
  logic q_empty;
  cmd_t q_wr_data;
  cmd_t q_rd_data;

  assign full = q_full;

  // Front: delta, classification and record state.
  rhle_front #(
    .ESCAPE_LIMIT(ESCAPE_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .time_ms   (time_ms),
    .stream_id (stream_id),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_data    (q_wr_data)
  );

  // Command queue between the two halves.
  rhle_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  // Back: byte serializer and output register.
  rhle_back #(
    .ESCAPE_LIMIT(ESCAPE_LIMIT)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_data          (q_rd_data),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .last_byte       (last_byte),
    .records_written (records_written)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import rhle_pkg::*;

  localparam logic [63:0] ESC_LIMIT = 64'(ESCAPE_LIMIT_DEF);
  localparam logic [63:0] T_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 1200000;

  // One header byte as it should leave the block.
  typedef struct packed {
    logic [7:0]  value;
    logic        last;
    logic [31:0] count;
  } hdr_byte_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;
  logic                 push;
  logic                 full;
  logic signed [63:0]   time_ms;
  logic [7:0]           stream_id;
  logic                 empty;
  logic                 pop;
  logic [7:0]           out_byte;
  logic                 last_byte;
  logic [31:0]          records_written;

  // Mirror of the block's settings and history.
  logic        multi_mode;
  logic [63:0] last_stamp;
  logic [31:0] record_count;

  // Header bytes still owed by the block, oldest first.
  hdr_byte_t hdr_build[$];
  hdr_byte_t header_due[$];
  hdr_byte_t want_byte;

  bit calm;
  int errors;
  int cycles;
  int stall_left;

  record_header_delta_leb128_encoder uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .time_ms         (time_ms),
    .stream_id       (stream_id),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .last_byte       (last_byte),
    .records_written (records_written)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic [31:0] cnt);
    hdr_byte_t hb;
    hb.value = b;
    hb.last  = 1'b0;
    hb.count = cnt;
    hdr_build.push_back(hb);
  endfunction

  // Unsigned LEB128: seven bits per byte, bit 7 set while more follow.
  function automatic void add_uleb(input logic [63:0] v, input logic [31:0] cnt);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      add_byte(b, cnt);
    end while (v != 0);
  endfunction

  // Signed LEB128: stop once the rest is pure sign and bit 6 agrees with it.
  function automatic void add_sleb(input logic [63:0] v, input logic [31:0] cnt);
    logic [7:0] b;
    logic       fin;
    fin = 1'b0;
    while (!fin) begin
      b = {1'b0, v[6:0]};
      v = {{7{v[63]}}, v[63:7]};
      fin = (v == 64'd0 && !b[6]) || (&v && b[6]);
      if (!fin) b[7] = 1'b1;
      add_byte(b, cnt);
    end
  endfunction

  // Work out the header of one accepted record and queue its bytes.
  function automatic void encode_header(input logic [63:0] stamp, input logic [7:0] sid);
    logic [63:0] delta;
    logic [31:0] cnt;
    delta = stamp - last_stamp;
    cnt = record_count + 32'd1;
    hdr_build.delete();
    if (delta[63] || delta >= ESC_LIMIT) begin
      add_uleb(ESC_LIMIT, cnt);
      add_sleb(delta, cnt);
    end else begin
      add_uleb(delta, cnt);
    end
    if (multi_mode) add_byte(sid, cnt);
    hdr_build[hdr_build.size() - 1].last = 1'b1;
    foreach (hdr_build[i]) header_due.push_back(hdr_build[i]);
    last_stamp = stamp;
    record_count = cnt;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want, input logic [31:0] rec);
    errors++;
    if (errors <= 40)
      $display("tb: mismatch on %s, record %0d: got %0h, expected %0h",
               field, rec, got, want);
  endtask

  // Offer one item and hold it until the block takes it.
  task automatic send_record(input logic [63:0] stamp, input logic [7:0] sid);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    time_ms   <= stamp;
    stream_id <= sid;
    @(posedge clk);
    while (full) @(posedge clk);
    encode_header(stamp, sid);
  endtask

  // Stop sending and wait until every owed byte has been taken.
  task automatic wait_all_popped();
    push <= 1'b0;
    @(posedge clk);
    while (header_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_MULTI_STREAM) begin
      multi_mode = data[0];
    end else if (idx == REG_START_TIME) begin
      last_stamp = data;
      record_count = 32'd0;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Deltas on both sides of the first LEB128 length step and of the escape limit.
  task automatic test_delta_ranges();
    send_record(last_stamp, 8'h00);
    send_record(last_stamp + 64'd1, 8'hFF);
    send_record(last_stamp + 64'd127, 8'h01);
    send_record(last_stamp + 64'd128, 8'h80);
    send_record(last_stamp + ESC_LIMIT - 64'd1, 8'h7F);
    send_record(last_stamp + ESC_LIMIT, 8'hFE);
    send_record(last_stamp - 64'd1, 8'h00);
  endtask

  // Stream byte on and off; only bit 0 of the mode register counts.
  task automatic test_stream_byte();
    wait_all_popped();
    write_reg(REG_MULTI_STREAM, 64'hFFFF_FFFF_FFFF_FFFF);
    send_record(last_stamp + 64'd5, 8'h00);
    send_record(last_stamp + 64'd300, 8'hFF);
    send_record(last_stamp - 64'd2, 8'hAA);
    send_record(last_stamp + ESC_LIMIT, 8'h55);
    wait_all_popped();
    write_reg(REG_MULTI_STREAM, 64'hFFFF_FFFF_FFFF_FFFE);
    send_record(last_stamp + 64'd3, 8'hFF);
  endtask

  // Wrapping subtraction at the ends of the range, and the longest header.
  task automatic test_wrapping_delta();
    wait_all_popped();
    write_reg(REG_MULTI_STREAM, 64'd1);
    write_reg(REG_START_TIME, T_MIN);
    send_record(T_MAX, 8'h0F);
    send_record(T_MIN, 8'hF0);
    wait_all_popped();
    write_reg(REG_START_TIME, 64'd0);
    send_record(T_MIN, 8'hC3);
    wait_all_popped();
    write_reg(REG_START_TIME, 64'd0);
    send_record(T_MAX, 8'h3C);
    send_record(64'd0, 8'h5A);
  endtask

  // Mostly steady timestamp streams, mixed with escapes and wild jumps.
  task automatic test_random_traffic();
    logic [63:0] stamp;
    int          r;
    for (int phase = 0; phase < 4; phase++) begin
      wait_all_popped();
      write_reg(REG_MULTI_STREAM, {$urandom, $urandom});
      case (phase)
        0: write_reg(REG_START_TIME, {$urandom, $urandom});
        1: write_reg(REG_START_TIME, T_MIN);
        2: write_reg(REG_START_TIME, T_MAX);
        default: write_reg(REG_START_TIME, 64'd0);
      endcase
      for (int i = 0; i < 100; i++) begin
        calm = (i % 50) >= 40;
        if (i == 37 || i == 74) wait_all_popped();
        r = $urandom_range(0, 99);
        if (r < 55) stamp = last_stamp + $urandom_range(0, 300);
        else if (r < 70) stamp = last_stamp + $urandom_range(0, ESCAPE_LIMIT_DEF);
        else if (r < 80) stamp = last_stamp + ESC_LIMIT - 64'd2 + $urandom_range(0, 4);
        else if (r < 90) stamp = last_stamp - $urandom_range(1, 1000000);
        else stamp = {$urandom, $urandom};
        send_record(stamp, 8'($urandom));
      end
      calm = 1'b0;
    end
  endtask

  // Take results with random stalls and compare each with the oldest owed byte.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else begin
      if (pop && !empty) begin
        if (header_due.size() == 0) begin
          report_mismatch("unexpected item", 64'(out_byte), 64'd0, records_written);
        end else begin
          want_byte = header_due.pop_front();
          if (out_byte !== want_byte.value)
            report_mismatch("out_byte", 64'(out_byte), 64'(want_byte.value),
                            want_byte.count);
          if (last_byte !== want_byte.last)
            report_mismatch("last_byte", 64'(last_byte), 64'(want_byte.last),
                            want_byte.count);
          if (records_written !== want_byte.count)
            report_mismatch("records_written", 64'(records_written),
                            64'(want_byte.count), want_byte.count);
        end
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = 64'd0;
    push = 1'b0;
    time_ms = 64'd0;
    stream_id = 8'd0;
    pop = 1'b0;
    calm = 1'b0;
    errors = 0;
    cycles = 0;
    stall_left = 0;
    multi_mode = 1'b0;
    last_stamp = 64'd0;
    record_count = 32'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_delta_ranges();
    test_stream_byte();
    test_wrapping_delta();
    test_random_traffic();
    wait_all_popped();
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
